[rtl/core/ptt_pkg.sv]
package ptt_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);

  // operation codes
  localparam logic [1:0] FN_CREATE = 2'd0;
  localparam logic [1:0] FN_DELETE = 2'd1;
  localparam logic [1:0] FN_POLL   = 2'd2;
  // the one code that names no operation
  localparam logic [1:0] FN_UNUSED = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_NONE      = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] timer_id;
    logic [31:0] period_us;
    logic [31:0] user_tag;
    logic [31:0] now_us;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] expired_id;
    logic [31:0] expired_period_us;
    logic [31:0] expired_tag;
  } res_t;

  // one slot record as held in the slot memory
  typedef struct packed {
    logic [15:0] id;
    logic [31:0] period;
    logic [31:0] start;
    logic [31:0] tag;
  } slot_t;

endpackage

[rtl/core/ptt_if.sv]
interface ptt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] timer_id;
  logic [31:0] period_us;
  logic [31:0] user_tag;
  logic [31:0] now_us;

  modport source (output valid, func, timer_id, period_us, user_tag, now_us, input ready);
  modport sink   (input valid, func, timer_id, period_us, user_tag, now_us, output ready);
endinterface

interface ptt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] expired_id;
  logic [31:0] expired_period_us;
  logic [31:0] expired_tag;

  modport source (output valid, status, expired_id, expired_period_us, expired_tag,
                  input ready);
  modport sink   (input valid, status, expired_id, expired_period_us, expired_tag,
                  output ready);
endinterface

[rtl/core/periodic_timer_table.sv]
// Result: for an unused code or a create on a full table the result word is decided before
//   any slot is read, else when slot k decides it; either way it then enters the output register.
// Throughput: one request per scan, which steps through the single read port of the slot
//   memory, one slot record a cycle; no new request is taken while a result is held.
// Reset (rst_n, synchronous, active low): valid marks, active count and margin clear at
//   once; slot records stay undefined until written, with no clearing pass.
module periodic_timer_table (
  input  logic        clk,
  input  logic        rst_n,
  ptt_req_if.sink     in_req,
  ptt_rsp_if.source   out_rsp,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  logic [15:0]   margin_r;
  logic          out_valid_r;
  ptt_pkg::res_t out_r;
  ptt_pkg::req_t req;
  ptt_pkg::res_t res;
  logic          res_valid, res_ready;

  // margin register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= '0;
    end else if (cfg_we) begin
      margin_r <= cfg_wdata;
    end
  end

  assign req.func      = in_req.func;
  assign req.timer_id  = in_req.timer_id;
  assign req.period_us = in_req.period_us;
  assign req.user_tag  = in_req.user_tag;
  assign req.now_us    = in_req.now_us;

  ptt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_req.valid),
    .req_ready (in_req.ready),
    .req       (req),
    .margin    (margin_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register: take a new word once the held one is gone
  assign res_ready = !out_valid_r || out_rsp.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_rsp.valid             = out_valid_r;
  assign out_rsp.status            = out_r.status;
  assign out_rsp.expired_id        = out_r.expired_id;
  assign out_rsp.expired_period_us = out_r.expired_period_us;
  assign out_rsp.expired_tag       = out_r.expired_tag;
endmodule

[rtl/core/ptt_ram.sv]
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/ptt_ctrl.sv]
module ptt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  output logic          req_ready,
  input  ptt_pkg::req_t req,
  input  logic [15:0]   margin,
  output logic          res_valid,
  input  logic          res_ready,
  output ptt_pkg::res_t res
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;
  localparam logic [ptt_pkg::IDX_W-1:0] LAST_IDX = ptt_pkg::IDX_W'(ptt_pkg::NUM_TIMERS - 1);
  localparam logic [ptt_pkg::CNT_W-1:0] FULL_CNT = ptt_pkg::CNT_W'(ptt_pkg::NUM_TIMERS);

  logic [1:0]                     state_r, state_nxt;
  ptt_pkg::req_t                  req_r, req_nxt;
  ptt_pkg::res_t                  res_r, res_nxt;
  logic [ptt_pkg::IDX_W-1:0]      issue_idx_r, issue_idx_nxt;
  logic                           issue_on_r, issue_on_nxt;
  logic [ptt_pkg::IDX_W-1:0]      e_idx_r, e_idx_nxt;
  logic                           pend_r, pend_nxt;
  logic [ptt_pkg::NUM_TIMERS-1:0] valid_r, valid_nxt;
  logic [ptt_pkg::CNT_W-1:0]      count_r, count_nxt;

  ptt_pkg::slot_t rd_slot, wr_slot;
  logic           ram_we;
  logic           valid_e, hit, early, finish;
  logic [31:0]    elapsed;
  logic [32:0]    reach;
  ptt_pkg::res_t  res_c;

  ptt_ram #(
    .WIDTH ($bits(ptt_pkg::slot_t)),
    .DEPTH (ptt_pkg::NUM_TIMERS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (e_idx_r),
    .wdata (wr_slot),
    .raddr (issue_idx_r),
    .rdata (rd_slot)
  );

  // judge the slot whose record arrived this cycle
  always_comb begin
    valid_e = valid_r[e_idx_r];
    elapsed = req_r.now_us - rd_slot.start;
    // elapsed >= period - margin (saturating) is elapsed + margin >= period
    reach   = {1'b0, elapsed} + {17'b0, margin};
    case (req_r.func)
      ptt_pkg::FN_CREATE: hit = !valid_e;
      ptt_pkg::FN_DELETE: hit = valid_e && (rd_slot.id == req_r.timer_id);
      ptt_pkg::FN_POLL:   hit = valid_e && (reach >= {1'b0, rd_slot.period});
      default:            hit = 1'b0;
    endcase
    early  = (req_r.func == ptt_pkg::FN_UNUSED) ||
             ((req_r.func == ptt_pkg::FN_CREATE) && (count_r == FULL_CNT));
    finish = (state_r == S_SCAN) &&
             (early || (pend_r && (hit || (e_idx_r == LAST_IDX))));
  end

  // form the result word
  always_comb begin
    res_c = '0;
    if (early) begin
      res_c.status = (req_r.func == ptt_pkg::FN_CREATE) ? ptt_pkg::ST_FULL : ptt_pkg::ST_NONE;
    end else if (hit) begin
      res_c.status = ptt_pkg::ST_OK;
      if (req_r.func == ptt_pkg::FN_POLL) begin
        res_c.expired_id        = rd_slot.id;
        res_c.expired_period_us = rd_slot.period;
        res_c.expired_tag       = rd_slot.tag;
      end
    end else begin
      case (req_r.func)
        ptt_pkg::FN_CREATE: res_c.status = ptt_pkg::ST_FULL;
        ptt_pkg::FN_DELETE: res_c.status = ptt_pkg::ST_NOT_FOUND;
        default:            res_c.status = ptt_pkg::ST_NONE;
      endcase
    end
  end

  // write back the chosen slot: new record on create, rearm on poll
  always_comb begin
    ram_we  = finish && !early && hit && (req_r.func != ptt_pkg::FN_DELETE);
    wr_slot = rd_slot;
    if (req_r.func == ptt_pkg::FN_CREATE) begin
      wr_slot.id     = req_r.timer_id;
      wr_slot.period = req_r.period_us;
      wr_slot.tag    = req_r.user_tag;
    end
    wr_slot.start = req_r.now_us;
  end

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = finish || (state_r == S_HOLD);
  assign res       = (state_r == S_HOLD) ? res_r : res_c;

  // sequencer: issue one read a cycle, judge one slot a cycle
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    issue_idx_nxt = issue_idx_r;
    issue_on_nxt  = issue_on_r;
    e_idx_nxt     = e_idx_r;
    pend_nxt      = pend_r;
    valid_nxt     = valid_r;
    count_nxt     = count_r;
    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          req_nxt       = req;
          issue_idx_nxt = '0;
          issue_on_nxt  = 1'b1;
          pend_nxt      = 1'b0;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        pend_nxt  = issue_on_r;
        e_idx_nxt = issue_idx_r;
        if (issue_idx_r == LAST_IDX) begin
          issue_on_nxt = 1'b0;
        end else begin
          issue_idx_nxt = issue_idx_r + 1'b1;
        end
        if (finish) begin
          if (!early && hit) begin
            if (req_r.func == ptt_pkg::FN_CREATE) begin
              valid_nxt[e_idx_r] = 1'b1;
              count_nxt          = count_r + 1'b1;
            end else if (req_r.func == ptt_pkg::FN_DELETE) begin
              valid_nxt[e_idx_r] = 1'b0;
              count_nxt          = count_r - 1'b1;
            end
          end
          res_nxt   = res_c;
          state_nxt = res_ready ? S_IDLE : S_HOLD;
        end
      end
      S_HOLD: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      issue_on_r <= 1'b0;
      pend_r     <= 1'b0;
      valid_r    <= '0;
      count_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      issue_on_r <= issue_on_nxt;
      pend_r     <= pend_nxt;
      valid_r    <= valid_nxt;
      count_r    <= count_nxt;
    end
    req_r       <= req_nxt;
    res_r       <= res_nxt;
    issue_idx_r <= issue_idx_nxt;
    e_idx_r     <= e_idx_nxt;
  end
endmodule

[rtl/core/ptt_checker.sv]
module ptt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [15:0] expired_id,
  input logic [31:0] expired_period_us,
  input logic [31:0] expired_tag
);
  // one request at a time: input closes after a word is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a request is in progress");

  // only a successful answer carries slot contents
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ptt_pkg::ST_OK) |->
      (expired_id == 16'd0) && (expired_period_us == 32'd0) && (expired_tag == 32'd0))
    else $error("failed answer carries slot contents");

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word withdrawn while stalled");

  // a stalled result word keeps its status
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(status))
    else $error("result status changed while stalled");
endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_req.valid),
  .in_ready          (in_req.ready),
  .out_valid         (out_rsp.valid),
  .out_ready         (out_rsp.ready),
  .status            (out_rsp.status),
  .expired_id        (out_rsp.expired_id),
  .expired_period_us (out_rsp.expired_period_us),
  .expired_tag       (out_rsp.expired_tag)
);
